// File: rtl/text_cursor_layout_engine_core_assert.svh
// Assertion macros for the text cursor layout engine.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TEXT_CURSOR_LAYOUT_ENGINE_CORE_ASSERT_SVH
`define TEXT_CURSOR_LAYOUT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define TCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcl assertion failed: same-cycle check");

// next-cycle implication
`define TCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcl assertion failed: next-cycle check");

`endif

// File: rtl/tcl_pkg.sv
// Shared types and constants for the text cursor layout engine.
// No dependencies.
package tcl_pkg;

  typedef enum logic [3:0] {
    ACT_DRAW      = 4'd0,
    ACT_NEWLINE   = 4'd1,
    ACT_TAB       = 4'd2,
    ACT_LEAD_PEND = 4'd3,
    ACT_PAIR      = 4'd4,
    ACT_LONE      = 4'd5,
    ACT_NONPRINT  = 4'd6,
    ACT_RANGE     = 4'd7,
    ACT_STOPPED   = 4'd8,
    ACT_RESET     = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } st_t;

  localparam logic [2:0] REG_GLYPH_COUNT = 3'd0;
  localparam logic [2:0] REG_CHAR_WIDTH  = 3'd1;
  localparam logic [2:0] REG_CHAR_HEIGHT = 3'd2;
  localparam logic [2:0] REG_LETTER_SP   = 3'd3;
  localparam logic [2:0] REG_LINE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_TAB_PITCH   = 3'd5;
  localparam logic [2:0] REG_GLYPH_CAP   = 3'd6;

  localparam int CFG_DW = 16;
  localparam int TS_W   = 10;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } stat_t;

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  endfunction

  function automatic logic is_trail(input logic [7:0] c);
    return (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
  endfunction

endpackage

// File: rtl/tcl_ctrl.sv
// Controller FSM for the text cursor layout engine.
// Depends on tcl_pkg.
module tcl_ctrl import tcl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.need_div ? S_DIV : S_OUT;
      S_DIV:  if (stat.div_done) state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.div_start = stat.need_div;
        cmd.commit    = !stat.need_div;
      end
      S_DIV:  cmd.commit = stat.div_done;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/tcl_div.sv
// Bit-serial remainder unit: pen x modulo the tab stop, one bit a cycle.
// Depends on tcl_pkg.
module tcl_div import tcl_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [TS_W-1:0]       divisor,
  output logic                  done,
  output logic [TS_W-1:0]       rem
);

  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] sh_r, sh_nxt;
  logic [TS_W-1:0]       rem_r, rem_nxt;
  logic [TS_W:0]         trial;

  always_comb begin
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    trial   = {rem_r, sh_r[COORD_BITS-1]};
    if (start) begin
      cnt_nxt = CNT_W'(COORD_BITS);
      sh_nxt  = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      sh_nxt  = sh_r << 1;
      // remainder stays below the divisor, so it fits after the subtract
      if (trial >= {1'b0, divisor}) rem_nxt = TS_W'(trial - {1'b0, divisor});
      else                          rem_nxt = TS_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = (cnt_r == '0);
  assign rem  = rem_r;

endmodule

// File: rtl/tcl_dp.sv
// Datapath: config registers, pen and counters, byte classification, result register.
// Depends on tcl_pkg and tcl_div.
module tcl_dp import tcl_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DW-1:0]     cfg_wdata,
  input  logic                  in_kind,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_last_of_string,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [3:0]            out_action,
  output logic [COORD_BITS-1:0] out_x_pos,
  output logic [COORD_BITS-1:0] out_y_pos,
  output logic [7:0]            out_glyph_num,
  output logic [15:0]           out_drawn_in_string,
  output logic [COUNT_BITS-1:0] out_chars_drawn_total,
  output logic [COUNT_BITS-1:0] out_lines_total,
  output logic [COUNT_BITS-1:0] out_tabs_total,
  output logic [COUNT_BITS-1:0] out_sjis_pairs_total,
  output logic [COUNT_BITS-1:0] out_sjis_lone_total,
  output logic [COUNT_BITS-1:0] out_nonprintable_total,
  output logic [COUNT_BITS-1:0] out_out_of_range_total
);

  localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

  // configuration
  logic [8:0]      gc_r;
  logic [5:0]      cw_r, ch_r;
  logic [3:0]      ls_r;
  logic [7:0]      lh_r;
  logic [TS_W-1:0] ts_r;
  logic [15:0]     mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r <= '0; cw_r <= 6'd8; ch_r <= 6'd8; ls_r <= 4'd1;
      lh_r <= '0; ts_r <= '0;   mc_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GLYPH_COUNT: gc_r <= cfg_wdata[8:0];
        REG_CHAR_WIDTH:  cw_r <= cfg_wdata[5:0];
        REG_CHAR_HEIGHT: ch_r <= cfg_wdata[5:0];
        REG_LETTER_SP:   ls_r <= cfg_wdata[3:0];
        REG_LINE_HEIGHT: lh_r <= cfg_wdata[7:0];
        REG_TAB_PITCH:   ts_r <= cfg_wdata[TS_W-1:0];
        REG_GLYPH_CAP:   mc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // held request
  logic       kind_r, last_r;
  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      byte_r <= in_text_byte;
      last_r <= in_last_of_string;
    end
  end

  // state
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                  pend_r, pend_nxt, stop_r, stop_nxt;
  logic [15:0]           sd_r, sd_nxt, sd_rep;
  logic [COUNT_BITS-1:0] c_drawn_r, c_line_r, c_tab_r, c_pair_r, c_lone_r, c_np_r, c_rng_r;
  logic [COUNT_BITS-1:0] c_drawn_nxt, c_line_nxt, c_tab_nxt, c_pair_nxt, c_lone_nxt;
  logic [COUNT_BITS-1:0] c_np_nxt, c_rng_nxt;
  act_t                  act;
  logic [COORD_BITS-1:0] ox, oy;
  logic [7:0]            og;
  logic [7:0]            lh_eff;
  logic                  tab_hit;

  logic            div_done;
  logic [TS_W-1:0] rem;

  tcl_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (px_r),
    .divisor  (ts_r),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    lh_eff = (lh_r != '0) ? lh_r : ((ch_r != '0) ? {2'b00, ch_r} : 8'd1);
  end

  always_comb begin
    px_nxt = px_r; py_nxt = py_r; pend_nxt = pend_r; stop_nxt = stop_r; sd_nxt = sd_r;
    c_drawn_nxt = c_drawn_r; c_line_nxt = c_line_r; c_tab_nxt = c_tab_r;
    c_pair_nxt = c_pair_r; c_lone_nxt = c_lone_r; c_np_nxt = c_np_r; c_rng_nxt = c_rng_r;
    act     = ACT_RESET;
    og      = '0;
    tab_hit = 1'b0;
    if (kind_r) begin
      px_nxt = '0; py_nxt = '0; pend_nxt = 1'b0; stop_nxt = 1'b0; sd_nxt = '0;
      c_drawn_nxt = '0; c_line_nxt = '0; c_tab_nxt = '0; c_pair_nxt = '0;
      c_lone_nxt = '0; c_np_nxt = '0; c_rng_nxt = '0;
      act = ACT_RESET;
    end else if (pend_r && is_trail(byte_r)) begin
      pend_nxt   = 1'b0;
      c_pair_nxt = c_pair_r + ONE;
      act        = ACT_PAIR;
    end else begin
      // a pending lead that got no trail counts as lone, then the byte runs fresh
      pend_nxt = 1'b0;
      if (pend_r) c_lone_nxt = c_lone_r + ONE;
      if (stop_r || (mc_r != '0 && sd_r >= mc_r)) begin
        stop_nxt = 1'b1;
        act      = ACT_STOPPED;
      end else if (is_lead(byte_r)) begin
        if (last_r) begin
          c_lone_nxt = c_lone_nxt + ONE;
          act        = ACT_LONE;
        end else begin
          pend_nxt = 1'b1;
          act      = ACT_LEAD_PEND;
        end
      end else if (byte_r == 8'h0A) begin
        px_nxt     = '0;
        py_nxt     = py_r + COORD_BITS'(lh_eff);
        c_line_nxt = c_line_r + ONE;
        act        = ACT_NEWLINE;
      end else if (byte_r == 8'h09 && ts_r != '0) begin
        tab_hit   = 1'b1;
        // next multiple of the tab stop: x - (x mod ts) + ts
        px_nxt    = px_r - COORD_BITS'(rem) + COORD_BITS'(ts_r);
        c_tab_nxt = c_tab_r + ONE;
        act       = ACT_TAB;
      end else if (byte_r < 8'h20 || byte_r > 8'h7E) begin
        c_np_nxt = c_np_r + ONE;
        act      = ACT_NONPRINT;
      end else if ({1'b0, byte_r - 8'h20} >= gc_r) begin
        c_rng_nxt = c_rng_r + ONE;
        act       = ACT_RANGE;
      end else begin
        og          = byte_r - 8'h20;
        px_nxt      = px_r + COORD_BITS'(cw_r) + COORD_BITS'(ls_r);
        sd_nxt      = sd_r + 16'd1;
        c_drawn_nxt = c_drawn_r + ONE;
        act         = ACT_DRAW;
      end
    end
    ox     = (act == ACT_DRAW) ? px_r : px_nxt;
    oy     = (act == ACT_DRAW) ? py_r : py_nxt;
    sd_rep = sd_nxt;
    if (!kind_r && last_r) begin
      sd_nxt = '0; stop_nxt = 1'b0; pend_nxt = 1'b0;
    end
  end

  assign stat.need_div = tab_hit;
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pend_r <= 1'b0; stop_r <= 1'b0; sd_r <= '0;
      c_drawn_r <= '0; c_line_r <= '0; c_tab_r <= '0; c_pair_r <= '0;
      c_lone_r <= '0; c_np_r <= '0; c_rng_r <= '0;
    end else if (cmd.commit) begin
      px_r <= px_nxt; py_r <= py_nxt; pend_r <= pend_nxt; stop_r <= stop_nxt; sd_r <= sd_nxt;
      c_drawn_r <= c_drawn_nxt; c_line_r <= c_line_nxt; c_tab_r <= c_tab_nxt;
      c_pair_r <= c_pair_nxt; c_lone_r <= c_lone_nxt; c_np_r <= c_np_nxt;
      c_rng_r <= c_rng_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action             <= act;
      out_x_pos              <= ox;
      out_y_pos              <= oy;
      out_glyph_num          <= og;
      out_drawn_in_string    <= sd_rep;
      out_chars_drawn_total  <= c_drawn_nxt;
      out_lines_total        <= c_line_nxt;
      out_tabs_total         <= c_tab_nxt;
      out_sjis_pairs_total   <= c_pair_nxt;
      out_sjis_lone_total    <= c_lone_nxt;
      out_nonprintable_total <= c_np_nxt;
      out_out_of_range_total <= c_rng_nxt;
    end
  end

endmodule

// File: rtl/text_cursor_layout_engine_core.sv
// Top level of the text cursor layout engine: controller plus datapath.
// Depends on tcl_pkg, tcl_ctrl, tcl_dp, tcl_div and the assertion header.
//
// One byte request at a time: accepted in idle, evaluated the next cycle and
// presented as a result in the OUT state, held there until out_ready. A tab
// with a nonzero tab stop also runs the bit-serial remainder unit in the DIV
// state, stepping through every bit of pen x, before the new pen is committed.
// Config writes take effect at once and must be made while no request is in flight.
`include "text_cursor_layout_engine_core_assert.svh"
module text_cursor_layout_engine_core import tcl_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DW-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_last_of_string,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_action,
  output logic [COORD_BITS-1:0] out_x_pos,
  output logic [COORD_BITS-1:0] out_y_pos,
  output logic [7:0]            out_glyph_num,
  output logic [15:0]           out_drawn_in_string,
  output logic [COUNT_BITS-1:0] out_chars_drawn_total,
  output logic [COUNT_BITS-1:0] out_lines_total,
  output logic [COUNT_BITS-1:0] out_tabs_total,
  output logic [COUNT_BITS-1:0] out_sjis_pairs_total,
  output logic [COUNT_BITS-1:0] out_sjis_lone_total,
  output logic [COUNT_BITS-1:0] out_nonprintable_total,
  output logic [COUNT_BITS-1:0] out_out_of_range_total
);

  cmd_t  cmd;
  stat_t stat;

  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcl_dp #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_kind                (in_kind),
    .in_text_byte           (in_text_byte),
    .in_last_of_string      (in_last_of_string),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_action             (out_action),
    .out_x_pos              (out_x_pos),
    .out_y_pos              (out_y_pos),
    .out_glyph_num          (out_glyph_num),
    .out_drawn_in_string    (out_drawn_in_string),
    .out_chars_drawn_total  (out_chars_drawn_total),
    .out_lines_total        (out_lines_total),
    .out_tabs_total         (out_tabs_total),
    .out_sjis_pairs_total   (out_sjis_pairs_total),
    .out_sjis_lone_total    (out_sjis_lone_total),
    .out_nonprintable_total (out_nonprintable_total),
    .out_out_of_range_total (out_out_of_range_total)
  );

  // one request in flight: no new accept until its result is taken
  `TCL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !out_valid)
  `TCL_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `TCL_ASSERT_NXT(a_idle_after_take, out_valid && out_ready, in_ready && !out_valid)

endmodule
